// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros: assertion helpers shared by the RTL files
// Clocked properties on clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every clock edge outside reset.
`define ASSERT_SYNC(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication, checked on every clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- rtl/htir_pkg.sv -----
// ---------------------------------------------------------------------------
// htir_pkg: shared types and constants of the rehashing hash table
// Hash constants, load-factor ratio, operation codes and sequencer states.
// ---------------------------------------------------------------------------
package htir_pkg;

   localparam int DEF_INITIAL_CAPACITY = 256;
   localparam int DEF_MAX_CAPACITY     = 4096;
   localparam int DEF_REHASH_BATCH     = 8;
   localparam int DEF_DATA_WIDTH       = 32;

   localparam logic [31:0] MIX_MULT  = 32'h045d9f3b;
   localparam int          MIX_SHIFT = 16;

   // grow when count * LOAD_DEN > capacity * LOAD_NUM
   localparam int LOAD_NUM = 7;
   localparam int LOAD_DEN = 10;

   localparam int COUNT_WIDTH = 13;

   localparam logic FUNC_PUT = 1'b0;
   localparam logic FUNC_GET = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_MIG_RD,
      S_MIG_EV,
      S_MIG_HASH,
      S_MIG_CLR,
      S_REQ_HASH,
      S_REQ_SETUP,
      S_PRB_RD,
      S_PRB_EV,
      S_OLD_SETUP,
      S_INSERT,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      MODE_MIG,
      MODE_CUR,
      MODE_OLD
   } mode_type;

endpackage

// ----- rtl/htir_mix.sv -----
// ---------------------------------------------------------------------------
// htir_mix: xor-shift-multiply hash
// Multiplier output is registered; the final fold is combinational, so the
// hash of key_in shows in the cycle after key_in is presented.
// ---------------------------------------------------------------------------
module htir_mix (
   input  logic        clock,
   input  logic [31:0] key_in,
   output logic [31:0] hash
);
   import htir_pkg::*;

   logic [31:0] fold;
   logic [31:0] prod_ff;
   logic [31:0] prod_in;

   assign fold    = key_in ^ (key_in >> MIX_SHIFT);
   assign prod_in = fold * MIX_MULT;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign hash = prod_ff ^ (prod_ff >> MIX_SHIFT);

endmodule

// ----- rtl/hash_table_incremental_rehash_unit.sv -----
// ---------------------------------------------------------------------------
// hash_table_incremental_rehash_unit: linear-probing table with incremental
// rehash
// Two ping-pong stores in one synchronous memory.
// ---------------------------------------------------------------------------
// One request is handled at a time. Every memory slot visited takes a read
// state and then an evaluate state, since each slot is read through one port
// with a registered read. A request first runs migration, then hashes the key
// and probes the current store; while a rehash is running, a miss there also
// probes the old store at or above the cursor. Migration scans old slots from
// the cursor and moves at most REHASH_BATCH entries per request, each one
// hashed, probed into the current store and cleared from the old one. A result
// waits in S_DONE until the output register is free. After reset the block
// sweeps both stores once before it raises req_ready. A finished result sits
// in the output register while the next request is taken.
module hash_table_incremental_rehash_unit #(
   parameter int INITIAL_CAPACITY = htir_pkg::DEF_INITIAL_CAPACITY,
   parameter int MAX_CAPACITY     = htir_pkg::DEF_MAX_CAPACITY,
   parameter int REHASH_BATCH     = htir_pkg::DEF_REHASH_BATCH,
   parameter int DATA_WIDTH       = htir_pkg::DEF_DATA_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [31:0] req_key,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic        rsp_found,
   output logic [31:0] rsp_data_out,
   output logic [htir_pkg::COUNT_WIDTH-1:0] rsp_entry_count
);
   import htir_pkg::*;

   localparam int AW       = $clog2(MAX_CAPACITY);
   localparam int LW       = $clog2(AW + 1);
   localparam int MVW      = $clog2(REHASH_BATCH + 1);
   localparam int MW       = 1 + 32 + DATA_WIDTH;
   localparam int INIT_LOG = $clog2(INITIAL_CAPACITY);
   localparam int MAX_LOG  = AW;
   localparam int CMPW     = (AW + 4 > 17) ? AW + 4 : 17;

   localparam logic [LW-1:0] LOG_LO = LW'(INIT_LOG);
   localparam logic [LW-1:0] LOG_HI = LW'(MAX_LOG);

   // memory: {store select, slot}, word {valid, key, data}
   logic [MW-1:0] mem [2*MAX_CAPACITY];
   logic [MW-1:0] rd_ff;
   logic          mem_we;
   logic [AW:0]   mem_wa;
   logic [MW-1:0] mem_wd;
   logic [AW:0]   mem_ra;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   logic                  func_ff, func_in;
   logic [31:0]           key_ff, key_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic                  cur_b_ff, cur_b_in;
   logic [LW-1:0]         cap_log_ff, cap_log_in;
   logic                  rehash_ff, rehash_in;
   logic [AW-1:0]         cursor_ff, cursor_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [MVW-1:0]        moved_ff, moved_in;
   logic [31:0]           hash_ff, hash_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [AW-1:0]         step_ff, step_in;
   logic                  ptbl_ff, ptbl_in;
   logic [AW-1:0]         pmask_ff, pmask_in;
   logic [31:0]           mig_key_ff, mig_key_in;
   logic [DATA_WIDTH-1:0] mig_data_ff, mig_data_in;
   logic                  nhole_ok_ff, nhole_ok_in;
   logic [AW-1:0]         nhole_ff, nhole_in;
   logic                  res_status_ff, res_status_in;
   logic                  res_found_ff, res_found_in;
   logic [DATA_WIDTH-1:0] res_data_ff, res_data_in;
   logic [AW:0]           clr_ff, clr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_status_ff, rsp_status_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [31:0]           rsp_data_ff, rsp_data_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;

   logic [31:0]           mix_key;
   logic [31:0]           mix_hash;
   logic [AW:0]           cap_full;
   logic [AW:0]           ocap_full;
   logic [AW-1:0]         cap_mask;
   logic [AW-1:0]         ocap_mask;
   logic                  grow_ok;
   logic                  rd_valid;
   logic [31:0]           rd_key;
   logic [DATA_WIDTH-1:0] rd_data;
   logic [31:0]           probe_key;
   logic                  below;
   logic                  hit_w;
   logic                  hole_w;
   logic [AW-1:0]         ostart;

   htir_mix u_mix (
      .clock  (clock),
      .key_in (mix_key),
      .hash   (mix_hash)
   );

   assign cap_full  = (AW+1)'(1) << cap_log_ff;
   assign ocap_full = cap_full >> 1;
   assign cap_mask  = AW'(cap_full - (AW+1)'(1));
   assign ocap_mask = cap_mask >> 1;

   assign grow_ok = (func_ff == FUNC_PUT) && !rehash_ff
                  && (CMPW'(count_ff) * CMPW'(LOAD_DEN) > CMPW'(cap_full) * CMPW'(LOAD_NUM))
                  && (cap_log_ff < LOG_HI);

   assign rd_valid = rd_ff[MW-1];
   assign rd_key   = rd_ff[MW-2:DATA_WIDTH];
   assign rd_data  = rd_ff[DATA_WIDTH-1:0];

   assign mix_key   = (state_ff == S_MIG_EV) ? rd_key : key_ff;
   assign probe_key = (mode_ff == MODE_MIG) ? mig_key_ff : key_ff;
   assign below     = (mode_ff == MODE_OLD) && (pos_ff < cursor_ff);
   assign hit_w     = !below && rd_valid && (rd_key == probe_key);
   assign hole_w    = !below && !rd_valid;

   always_comb begin
      ostart = AW'(hash_ff) & ocap_mask;
      if (ostart < cursor_ff) begin
         ostart = cursor_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[mem_ra];
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      cur_b_in      = cur_b_ff;
      cap_log_in    = cap_log_ff;
      rehash_in     = rehash_ff;
      cursor_in     = cursor_ff;
      count_in      = count_ff;
      moved_in      = moved_ff;
      hash_in       = hash_ff;
      pos_in        = pos_ff;
      step_in       = step_ff;
      ptbl_in       = ptbl_ff;
      pmask_in      = pmask_ff;
      mig_key_in    = mig_key_ff;
      mig_data_in   = mig_data_ff;
      nhole_ok_in   = nhole_ok_ff;
      nhole_in      = nhole_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_data_in   = res_data_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      req_ready     = 1'b0;
      mem_we        = 1'b0;
      mem_wa        = {ptbl_ff, pos_ff};
      mem_wd        = '0;
      mem_ra        = {ptbl_ff, pos_ff};

      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + (AW+1)'(1);
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in  = req_func;
               key_in   = req_key;
               value_in = DATA_WIDTH'(req_value);
               moved_in = '0;
               state_in = S_MIG_RD;
            end
         end
         S_MIG_RD: begin
            mem_ra = {~cur_b_ff, cursor_ff};
            if (rehash_ff && ((AW+1)'(cursor_ff) < ocap_full)
                && (moved_ff < MVW'(REHASH_BATCH))) begin
               state_in = S_MIG_EV;
            end else begin
               if (rehash_ff && ((AW+1)'(cursor_ff) >= ocap_full)) begin
                  rehash_in = 1'b0;
                  cursor_in = '0;
               end
               state_in = S_REQ_HASH;
            end
         end
         S_MIG_EV: begin
            if (rd_valid) begin
               mig_key_in  = rd_key;
               mig_data_in = rd_data;
               state_in    = S_MIG_HASH;
            end else begin
               cursor_in = cursor_ff + AW'(1);
               state_in  = S_MIG_RD;
            end
         end
         S_MIG_HASH: begin
            pos_in   = AW'(mix_hash) & cap_mask;
            step_in  = '0;
            mode_in  = MODE_MIG;
            ptbl_in  = cur_b_ff;
            pmask_in = cap_mask;
            state_in = S_PRB_RD;
         end
         S_MIG_CLR: begin
            // drop the moved entry from the old store
            mem_we    = 1'b1;
            mem_wa    = {~cur_b_ff, cursor_ff};
            moved_in  = moved_ff + MVW'(1);
            cursor_in = cursor_ff + AW'(1);
            state_in  = S_MIG_RD;
         end
         S_REQ_HASH: begin
            res_status_in = STATUS_OK;
            res_found_in  = 1'b0;
            res_data_in   = '0;
            nhole_ok_in   = 1'b0;
            if (grow_ok) begin
               cur_b_in   = ~cur_b_ff;
               cap_log_in = cap_log_ff + LW'(1);
               rehash_in  = 1'b1;
               cursor_in  = '0;
            end
            state_in = S_REQ_SETUP;
         end
         S_REQ_SETUP: begin
            hash_in  = mix_hash;
            pos_in   = AW'(mix_hash) & cap_mask;
            step_in  = '0;
            mode_in  = MODE_CUR;
            ptbl_in  = cur_b_ff;
            pmask_in = cap_mask;
            state_in = S_PRB_RD;
         end
         S_PRB_RD: begin
            state_in = S_PRB_EV;
         end
         S_PRB_EV: begin
            if (!below && rd_valid && !hit_w && (step_ff != pmask_ff)) begin
               // advance along the chain
               pos_in   = (pos_ff + AW'(1)) & pmask_ff;
               step_in  = step_ff + AW'(1);
               state_in = S_PRB_RD;
            end else begin
               unique case (mode_ff)
                  MODE_MIG: begin
                     if (hole_w) begin
                        mem_we = 1'b1;
                        mem_wd = {1'b1, mig_key_ff, mig_data_ff};
                     end else if (count_ff != '0) begin
                        count_in = count_ff - COUNT_WIDTH'(1);
                     end
                     state_in = S_MIG_CLR;
                  end
                  MODE_CUR: begin
                     if (hit_w) begin
                        res_found_in = 1'b1;
                        if (func_ff == FUNC_PUT) begin
                           mem_we = 1'b1;
                           mem_wd = {1'b1, key_ff, value_ff};
                        end else begin
                           res_data_in = rd_data;
                        end
                        state_in = S_DONE;
                     end else begin
                        nhole_ok_in = hole_w;
                        nhole_in    = pos_ff;
                        state_in    = rehash_ff ? S_OLD_SETUP : S_INSERT;
                     end
                  end
                  default: begin
                     if (hit_w) begin
                        res_found_in = 1'b1;
                        if (func_ff == FUNC_PUT) begin
                           mem_we = 1'b1;
                           mem_wd = {1'b1, key_ff, value_ff};
                        end else begin
                           res_data_in = rd_data;
                        end
                        state_in = S_DONE;
                     end else begin
                        state_in = S_INSERT;
                     end
                  end
               endcase
            end
         end
         S_OLD_SETUP: begin
            if ((AW+1)'(ostart) < ocap_full) begin
               pos_in   = ostart;
               step_in  = '0;
               mode_in  = MODE_OLD;
               ptbl_in  = ~cur_b_ff;
               pmask_in = ocap_mask;
               state_in = S_PRB_RD;
            end else begin
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            if (func_ff == FUNC_PUT) begin
               if (nhole_ok_ff) begin
                  mem_we   = 1'b1;
                  mem_wa   = {cur_b_ff, nhole_ff};
                  mem_wd   = {1'b1, key_ff, value_ff};
                  count_in = count_ff + COUNT_WIDTH'(1);
               end else begin
                  res_status_in = STATUS_FULL;
               end
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_data_in   = (func_ff == FUNC_PUT) ? '0 : 32'(res_data_ff);
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cur_b_ff     <= 1'b0;
         cap_log_ff   <= LOG_LO;
         rehash_ff    <= 1'b0;
         cursor_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cur_b_ff     <= cur_b_in;
         cap_log_ff   <= cap_log_in;
         rehash_ff    <= rehash_in;
         cursor_ff    <= cursor_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      func_ff       <= func_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      moved_ff      <= moved_in;
      hash_ff       <= hash_in;
      pos_ff        <= pos_in;
      step_ff       <= step_in;
      ptbl_ff       <= ptbl_in;
      pmask_ff      <= pmask_in;
      mig_key_ff    <= mig_key_in;
      mig_data_ff   <= mig_data_in;
      nhole_ok_ff   <= nhole_ok_in;
      nhole_ff      <= nhole_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_data_ff   <= res_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_entry_count = rsp_count_ff;

`include "assert_macros.svh"

   `ASSERT_IMPL(a_cursor_idle, !rehash_ff, cursor_ff == '0, "cursor moved while idle")
   `ASSERT_SYNC(a_cap_range, cap_log_ff >= LOG_LO && cap_log_ff <= LOG_HI, "capacity out of range")
   `ASSERT_IMPL(a_idle_no_write, state_ff == S_IDLE, !mem_we, "memory written while idle")
   `ASSERT_IMPL(a_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff == S_DONE), "early result")

endmodule
